[hdl/csms_pkg.sv]
`default_nettype none
package csms_pkg;

    // Control counts per kind
    localparam int FADER_COUNT  = 8;
    localparam int KNOB_COUNT   = 8;
    localparam int BUTTON_COUNT = 8;

    // Store address widths
    localparam int FADER_AW  = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
    localparam int KNOB_AW   = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
    localparam int BUTTON_AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int IDX_EXT_W = 6;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 3;
    localparam int RAW_W   = 12;
    localparam int LEVEL_W = 7;
    localparam int STORE_W = 8;
    localparam int NUM_W   = RAW_W + LEVEL_W;
    localparam int SHIFT_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd127;
    localparam logic [STORE_W-1:0] UNKNOWN_VALUE = 8'hFF;
    localparam logic [RAW_W-1:0]   RAW_MAX       = 12'd4095;
    localparam logic [RAW_W-1:0]   PRESS_RESET   = 12'd2048;
    localparam logic [SHIFT_W-1:0] DIV_TOP_SHIFT = 3'd6;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_FADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KNOB   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] EVT_CTRL_CHANGE = 2'd0;
    localparam logic [KIND_W-1:0] EVT_NOTE_ON     = 2'd1;
    localparam logic [KIND_W-1:0] EVT_NOTE_OFF    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADER_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADER_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADER_BASE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_BASE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_BASE   = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0]   fader_min;
        logic [RAW_W-1:0]   fader_max;
        logic [RAW_W-1:0]   knob_min;
        logic [RAW_W-1:0]   knob_max;
        logic [RAW_W-1:0]   press_level;
        logic [LEVEL_W-1:0] fader_base;
        logic [LEVEL_W-1:0] knob_base;
        logic [LEVEL_W-1:0] note_base;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic               prep;
        logic               div_step;
        logic [SHIFT_W-1:0] div_shift;
        logic               finish;
    } dp_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[hdl/csms_cfg.sv]
`default_nettype none
module csms_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [csms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csms_pkg::CFG_DATA_W-1:0] cfg_data,
    output csms_pkg::cfg_t                       cfg
);
    import csms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FADER_MIN:   cfg_next.fader_min   = cfg_data[RAW_W-1:0];
                REG_FADER_MAX:   cfg_next.fader_max   = cfg_data[RAW_W-1:0];
                REG_KNOB_MIN:    cfg_next.knob_min    = cfg_data[RAW_W-1:0];
                REG_KNOB_MAX:    cfg_next.knob_max    = cfg_data[RAW_W-1:0];
                REG_PRESS_LEVEL: cfg_next.press_level = cfg_data[RAW_W-1:0];
                REG_FADER_BASE:  cfg_next.fader_base  = cfg_data[LEVEL_W-1:0];
                REG_KNOB_BASE:   cfg_next.knob_base   = cfg_data[LEVEL_W-1:0];
                REG_NOTE_BASE:   cfg_next.note_base   = cfg_data[LEVEL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fader_min   <= '0;
            cfg_reg.fader_max   <= RAW_MAX;
            cfg_reg.knob_min    <= '0;
            cfg_reg.knob_max    <= RAW_MAX;
            cfg_reg.press_level <= PRESS_RESET;
            cfg_reg.fader_base  <= '0;
            cfg_reg.knob_base   <= '0;
            cfg_reg.note_base   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hdl/csms_ctrl.sv]
`default_nettype none
module csms_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  csms_pkg::dp_status_t      status,
    output csms_pkg::dp_cmd_t         cmd
);
    import csms_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] shift_next;

    always_comb
    begin
        state_next    = state_reg;
        shift_next    = shift_reg;
        cmd           = '0;
        cmd.div_shift = shift_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                shift_next = DIV_TOP_SHIFT;
                state_next = status.needs_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                shift_next   = shift_reg - 1'b1;
                if (shift_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register can take it
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
        end
    end

endmodule
`default_nettype wire

[hdl/csms_dp.sv]
`default_nettype none
module csms_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  csms_pkg::cfg_t                    cfg,
    input  csms_pkg::dp_cmd_t                 cmd,
    output csms_pkg::dp_status_t              status,
    input  wire logic [csms_pkg::KIND_W-1:0]  in_kind,
    input  wire logic [csms_pkg::IDX_W-1:0]   in_index,
    input  wire logic [csms_pkg::RAW_W-1:0]   in_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [csms_pkg::KIND_W-1:0]       out_event_kind,
    output logic [csms_pkg::LEVEL_W-1:0]      out_number,
    output logic [csms_pkg::LEVEL_W-1:0]      out_level
);
    import csms_pkg::*;

    // Captured item
    logic [KIND_W-1:0]  kind_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [RAW_W-1:0]   sample_reg;

    // Scaling and division
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   rem_next;
    logic [RAW_W-1:0]   den_reg;
    logic [LEVEL_W-1:0] quot_reg;
    logic [LEVEL_W-1:0] quot_next;
    logic               empty_reg;
    logic               pressed_reg;

    // Last-value stores
    logic [STORE_W-1:0] last_fader_reg  [FADER_COUNT];
    logic [STORE_W-1:0] last_knob_reg   [KNOB_COUNT];
    logic               last_button_reg [BUTTON_COUNT];

    // Output register
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [LEVEL_W-1:0] out_number_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    logic [RAW_W-1:0]     lo;
    logic [RAW_W-1:0]     hi;
    logic [RAW_W-1:0]     clamped;
    logic [RAW_W-1:0]     diff;
    logic [NUM_W-1:0]     trial;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [FADER_AW-1:0]  fader_addr;
    logic [KNOB_AW-1:0]   knob_addr;
    logic [BUTTON_AW-1:0] button_addr;
    logic [LEVEL_W-1:0]   scaled;
    logic                 idx_ok;
    logic                 emit;
    logic [KIND_W-1:0]    evt_kind;
    logic [LEVEL_W-1:0]   evt_number;
    logic [LEVEL_W-1:0]   evt_level;

    assign status.needs_div = (kind_reg == KIND_FADER) || (kind_reg == KIND_KNOB);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Clamp and offset
    always_comb
    begin
        if (kind_reg == KIND_FADER)
        begin
            lo = cfg.fader_min;
            hi = cfg.fader_max;
        end
        else
        begin
            lo = cfg.knob_min;
            hi = cfg.knob_max;
        end
        if (sample_reg < lo)
        begin
            clamped = lo;
        end
        else if (sample_reg > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = sample_reg;
        end
        diff = clamped - lo;
    end

    // One quotient bit per step
    always_comb
    begin
        trial     = NUM_W'(den_reg) << cmd.div_shift;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (rem_reg >= trial)
        begin
            rem_next                 = rem_reg - trial;
            quot_next[cmd.div_shift] = 1'b1;
        end
    end

    // Compare against the store and form the event
    always_comb
    begin
        idx_ext     = IDX_EXT_W'(idx_reg);
        fader_addr  = idx_ext[FADER_AW-1:0];
        knob_addr   = idx_ext[KNOB_AW-1:0];
        button_addr = idx_ext[BUTTON_AW-1:0];
        scaled      = empty_reg ? '0 : quot_reg;
        idx_ok      = 1'b0;
        emit        = 1'b0;
        evt_kind    = EVT_CTRL_CHANGE;
        evt_number  = '0;
        evt_level   = scaled;
        case (kind_reg)
            KIND_FADER:
            begin
                idx_ok     = int'(idx_reg) < FADER_COUNT;
                emit       = idx_ok && ({1'b0, scaled} != last_fader_reg[fader_addr]);
                evt_number = cfg.fader_base + LEVEL_W'(idx_reg);
            end
            KIND_KNOB:
            begin
                idx_ok     = int'(idx_reg) < KNOB_COUNT;
                emit       = idx_ok && ({1'b0, scaled} != last_knob_reg[knob_addr]);
                evt_number = cfg.knob_base + LEVEL_W'(idx_reg);
            end
            KIND_BUTTON:
            begin
                idx_ok     = int'(idx_reg) < BUTTON_COUNT;
                emit       = idx_ok && (pressed_reg != last_button_reg[button_addr]);
                evt_kind   = pressed_reg ? EVT_NOTE_ON : EVT_NOTE_OFF;
                evt_number = cfg.note_base + LEVEL_W'(idx_reg);
                evt_level  = pressed_reg ? LEVEL_MAX : '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            idx_reg    <= in_index;
            sample_reg <= in_sample;
        end
        if (cmd.prep)
        begin
            // diff * 127 as a shift and subtract
            rem_reg     <= {diff, {LEVEL_W{1'b0}}} - NUM_W'(diff);
            den_reg     <= hi - lo;
            empty_reg   <= hi <= lo;
            pressed_reg <= sample_reg >= cfg.press_level;
            quot_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (cmd.finish && emit)
        begin
            out_kind_reg   <= evt_kind;
            out_number_reg <= evt_number;
            out_level_reg  <= evt_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FADER_COUNT; i++)
            begin
                last_fader_reg[i] <= UNKNOWN_VALUE;
            end
            for (int i = 0; i < KNOB_COUNT; i++)
            begin
                last_knob_reg[i] <= UNKNOWN_VALUE;
            end
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                last_button_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.finish && emit)
            begin
                out_valid_reg <= 1'b1;
                case (kind_reg)
                    KIND_FADER:  last_fader_reg[fader_addr]    <= {1'b0, scaled};
                    KIND_KNOB:   last_knob_reg[knob_addr]      <= {1'b0, scaled};
                    KIND_BUTTON: last_button_reg[button_addr]  <= pressed_reg;
                    default:     ;
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_event_kind = out_kind_reg;
    assign out_number     = out_number_reg;
    assign out_level      = out_level_reg;

endmodule
`default_nettype wire

[hdl/control_surface_midi_scanner_top.sv]
// Control surface scanner: turns raw converter samples into change events.
// Input stream: s_tuser carries the control kind (fader, knob, button),
// s_tdata the control index and the 12-bit sample. Output stream: m_tuser
// carries the event kind (controller change, note on, note off), m_tdata
// the controller or note number and the level. An item yields zero or one
// event; nothing comes out when the value or pressed state did not change,
// for an unused kind, or for an index beyond that kind's count.
// A fader or knob item passes from the accepting edge through clamp and
// scale, 7 steps of the shift-subtract quotient unit, then store compare
// and commit into the output register; a button item skips the quotient.
// The controller is back in idle on the edge that commits the event, so
// the input takes a new item only once the last one is through.
// s_tready is high only while no item is in work. A finished event sits in
// the output register; the next item is taken while it waits, and that
// item's own result holds in the last step until m_tready frees the
// register. Reset clears the output register, sets the configuration to
// its defaults, marks every stored fader and knob value unknown so its
// first sample always reports, and marks every button released. Users must write
// configuration via cfg_wr_en/cfg_index/cfg_data while idle; not enforced.
`default_nettype none
module control_surface_midi_scanner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [2:0] index, [14:3] sample, [15] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] number, [13:7] level, [15:14] zero
    output logic [1:0]       m_tuser,   // [1:0] event_kind
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    import csms_pkg::*;

    cfg_t               cfg;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [LEVEL_W-1:0] number;
    logic [LEVEL_W-1:0] level;

    csms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequence one item through capture, scale, divide and commit
    csms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csms_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .in_kind        (s_tuser),
        .in_index       (s_tdata[IDX_W-1:0]),
        .in_sample      (s_tdata[IDX_W+RAW_W-1:IDX_W]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_event_kind (m_tuser),
        .out_number     (number),
        .out_level      (level)
    );

    // Pack the event, zero-filled to whole bytes
    assign m_tdata = {2'b00, level, number};

endmodule
`default_nettype wire

[sim/control_surface_midi_scanner_top_tb.sv]
`timescale 1ns / 1ps
module control_surface_midi_scanner_top_tb;
    import csms_pkg::*;

    // Cycles allowed for an item in work to leave the block.
    localparam int DRAIN_CYCLES   = 16;
    // Long receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_CYCLES    = 400;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 400;
    localparam int ITEMS_PER_CFG  = 100;
    // Kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  ekind;
        logic [LEVEL_W-1:0] number;
        logic [LEVEL_W-1:0] level;
    } midi_event_t;

    // Raw register image, indexed by register number.
    typedef logic [7:0][CFG_DATA_W-1:0] reg_image_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    // Shadow of the scanner: configuration and per-control history.
    cfg_t               shadow_cfg;
    logic [STORE_W-1:0] fader_last  [FADER_COUNT];
    logic [STORE_W-1:0] knob_last   [KNOB_COUNT];
    logic               button_down [BUTTON_COUNT];

    midi_event_t pending_events[$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_req  = 0;
    int          hold_ack  = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    control_surface_midi_scanner_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    task automatic reset_shadow();
        shadow_cfg.fader_min   = '0;
        shadow_cfg.fader_max   = RAW_MAX;
        shadow_cfg.knob_min    = '0;
        shadow_cfg.knob_max    = RAW_MAX;
        shadow_cfg.press_level = PRESS_RESET;
        shadow_cfg.fader_base  = '0;
        shadow_cfg.knob_base   = '0;
        shadow_cfg.note_base   = '0;
        // Stored values start unknown so the first sample always reports.
        for (int i = 0; i < FADER_COUNT; i++)
            fader_last[i] = UNKNOWN_VALUE;
        for (int i = 0; i < KNOB_COUNT; i++)
            knob_last[i] = UNKNOWN_VALUE;
        for (int i = 0; i < BUTTON_COUNT; i++)
            button_down[i] = 1'b0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] reg_idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (reg_idx)
            REG_FADER_MIN:   shadow_cfg.fader_min   = data;
            REG_FADER_MAX:   shadow_cfg.fader_max   = data;
            REG_KNOB_MIN:    shadow_cfg.knob_min    = data;
            REG_KNOB_MAX:    shadow_cfg.knob_max    = data;
            REG_PRESS_LEVEL: shadow_cfg.press_level = data;
            // Controller and note bases keep only their low 7 bits.
            REG_FADER_BASE:  shadow_cfg.fader_base  = data[LEVEL_W-1:0];
            REG_KNOB_BASE:   shadow_cfg.knob_base   = data[LEVEL_W-1:0];
            REG_NOTE_BASE:   shadow_cfg.note_base   = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Clamp to [lo, hi] and map onto 0..127, truncating; empty range gives 0.
    function automatic int scale_to_level(input int raw, input int lo, input int hi);
        int v;
        if (hi <= lo)
            return 0;
        v = raw;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return ((v - lo) * 127) / (hi - lo);
    endfunction

    // Work out the event, if any, that one sample causes; update history.
    function automatic bit scan_control(input logic [KIND_W-1:0] kind,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [RAW_W-1:0] sample,
                                        output midi_event_t ev);
        int  val;
        bit  pressed;
        ev = '0;
        case (kind)
            KIND_FADER:
            begin
                val = scale_to_level(int'(sample), int'(shadow_cfg.fader_min),
                                     int'(shadow_cfg.fader_max));
                if (val == int'(fader_last[idx]))
                    return 1'b0;
                fader_last[idx] = STORE_W'(val);
                ev.ekind  = EVT_CTRL_CHANGE;
                ev.number = shadow_cfg.fader_base + LEVEL_W'(idx);
                ev.level  = LEVEL_W'(val);
                return 1'b1;
            end
            KIND_KNOB:
            begin
                val = scale_to_level(int'(sample), int'(shadow_cfg.knob_min),
                                     int'(shadow_cfg.knob_max));
                if (val == int'(knob_last[idx]))
                    return 1'b0;
                knob_last[idx] = STORE_W'(val);
                ev.ekind  = EVT_CTRL_CHANGE;
                ev.number = shadow_cfg.knob_base + LEVEL_W'(idx);
                ev.level  = LEVEL_W'(val);
                return 1'b1;
            end
            KIND_BUTTON:
            begin
                pressed = (sample >= shadow_cfg.press_level);
                if (pressed == button_down[idx])
                    return 1'b0;
                button_down[idx] = pressed;
                ev.ekind  = pressed ? EVT_NOTE_ON : EVT_NOTE_OFF;
                ev.number = shadow_cfg.note_base + LEVEL_W'(idx);
                ev.level  = pressed ? LEVEL_MAX : '0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item after a random gap; hold it until accepted, then
    // queue the event it should cause. tvalid is left high on return.
    task automatic send_sample(input logic [KIND_W-1:0] kind,
                               input logic [IDX_W-1:0] idx,
                               input logic [RAW_W-1:0] sample);
        midi_event_t ev;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, sample, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (scan_control(kind, idx, sample, ev))
            pending_events.push_back(ev);
    endtask

    // Drop tvalid, wait for every queued event, then let any item that
    // produces nothing work its way out of the block.
    task automatic drain_scanner();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all registers back to back while the block is idle.
    task automatic load_config(input reg_image_t image);
        drain_scanner();
        for (int r = REG_FADER_MIN; r <= REG_NOTE_BASE; r++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= image[r];
            @(posedge clk);
            apply_register(CFG_IDX_W'(r), image[r]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return RAW_MAX;
            2:       return RAW_W'($urandom_range(15));
            default: return RAW_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic reg_image_t random_image();
        reg_image_t image;
        image[REG_FADER_MIN]   = pick_limit();
        image[REG_FADER_MAX]   = pick_limit();
        image[REG_KNOB_MIN]    = pick_limit();
        image[REG_KNOB_MAX]    = pick_limit();
        image[REG_PRESS_LEVEL] = pick_limit();
        // Full 12-bit data on the base registers exercises the masking.
        image[REG_FADER_BASE]  = CFG_DATA_W'($urandom_range(4095));
        image[REG_KNOB_BASE]   = CFG_DATA_W'($urandom_range(4095));
        image[REG_NOTE_BASE]   = CFG_DATA_W'($urandom_range(4095));
        return image;
    endfunction

    // Samples cluster on the extremes and around the configured limits,
    // where clamping, truncation and the press threshold decide.
    function automatic logic [RAW_W-1:0] pick_sample(input logic [KIND_W-1:0] kind);
        int pivot;
        int s;
        case ($urandom_range(9))
            0: return '0;
            1: return RAW_MAX;
            2, 3:
            begin
                if (kind == KIND_BUTTON)
                    pivot = int'(shadow_cfg.press_level);
                else if (kind == KIND_KNOB)
                    pivot = $urandom_range(1) ? int'(shadow_cfg.knob_min)
                                              : int'(shadow_cfg.knob_max);
                else
                    pivot = $urandom_range(1) ? int'(shadow_cfg.fader_min)
                                              : int'(shadow_cfg.fader_max);
                s = pivot + int'($urandom_range(6)) - 3;
                if (s < 0)
                    s = 0;
                if (s > 4095)
                    s = 4095;
                return s[RAW_W-1:0];
            end
            default: return RAW_W'($urandom_range(4095));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver, event checker and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event: expected none, got kind %0d number %0d level %0d",
                         $time, m_tuser, m_tdata[6:0], m_tdata[13:7]);
                mismatch_count++;
            end
            else
            begin
                automatic midi_event_t want = pending_events.pop_front();
                if (m_tuser !== want.ekind || m_tdata[6:0] !== want.number ||
                    m_tdata[13:7] !== want.level)
                begin
                    $display("%0t: event mismatch: expected kind %0d number %0d level %0d,",
                             $time, want.ekind, want.number, want.level);
                    $display("    got kind %0d number %0d level %0d",
                             m_tuser, m_tdata[6:0], m_tdata[13:7]);
                    mismatch_count++;
                end
            end
        end
        // A new hold request starts a long hold-off; otherwise stall at random.
        if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: full ranges, threshold at mid scale, bases zero.
    task automatic test_reset_defaults();
        send_sample(KIND_FADER, 0, 12'd0);
        send_sample(KIND_FADER, 0, 12'd4095);
        send_sample(KIND_FADER, 0, 12'd4095);      // unchanged: nothing
        send_sample(KIND_KNOB, 7, 12'd2048);
        send_sample(KIND_KNOB, 7, 12'd0);
        send_sample(KIND_BUTTON, 0, 12'd2048);     // exactly at threshold
        send_sample(KIND_BUTTON, 0, 12'd2047);
        send_sample(KIND_BUTTON, 7, 12'd4095);
        send_sample(KIND_UNUSED, 5, 12'd4095);     // ignored kind
        send_sample(KIND_FADER, 3, 12'd1);         // unknown history, level 0
    endtask

    // Narrow fader range, empty knob range, threshold zero, wrapping bases.
    task automatic test_ranges_and_bases();
        reg_image_t image;
        image[REG_FADER_MIN]   = 12'd1000;
        image[REG_FADER_MAX]   = 12'd3000;
        image[REG_KNOB_MIN]    = 12'd3000;
        image[REG_KNOB_MAX]    = 12'd3000;
        image[REG_PRESS_LEVEL] = 12'd0;
        image[REG_FADER_BASE]  = 12'hFFF;
        image[REG_KNOB_BASE]   = 12'h07E;
        image[REG_NOTE_BASE]   = 12'hF85;
        load_config(image);
        send_sample(KIND_FADER, 1, 12'd999);       // clamps low
        send_sample(KIND_FADER, 1, 12'd3001);      // clamps high
        send_sample(KIND_FADER, 1, 12'd2000);
        send_sample(KIND_KNOB, 2, 12'd4095);       // empty range gives 0
        send_sample(KIND_KNOB, 2, 12'd0);
        send_sample(KIND_BUTTON, 6, 12'd0);        // any level counts as pressed
        send_sample(KIND_BUTTON, 0, 12'd0);
        send_sample(KIND_FADER, 7, 12'd2000);      // number wraps past 127
    endtask

    // Inverted fader range, one-step knob range, threshold at full scale.
    task automatic test_inverted_and_tiny_ranges();
        reg_image_t image;
        image[REG_FADER_MIN]   = 12'd4095;
        image[REG_FADER_MAX]   = 12'd0;
        image[REG_KNOB_MIN]    = 12'd0;
        image[REG_KNOB_MAX]    = 12'd1;
        image[REG_PRESS_LEVEL] = 12'd4095;
        image[REG_FADER_BASE]  = 12'd0;
        image[REG_KNOB_BASE]   = 12'd0;
        image[REG_NOTE_BASE]   = 12'd0;
        load_config(image);
        send_sample(KIND_FADER, 1, 12'd4095);
        send_sample(KIND_KNOB, 7, 12'd1);
        send_sample(KIND_KNOB, 7, 12'd0);
        send_sample(KIND_BUTTON, 6, 12'd4094);
        send_sample(KIND_BUTTON, 6, 12'd4095);
        send_sample(KIND_FADER, 0, 12'd0);
        send_sample(KIND_UNUSED, 0, 12'd0);
    endtask

    task automatic run_traffic_phase(input int idle_pct, input int stall_pct);
        logic [KIND_W-1:0] kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % ITEMS_PER_CFG == 0)
                load_config(random_image());
            kind = ($urandom_range(15) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(2));
            send_sample(kind, IDX_W'($urandom_range(7)), pick_sample(kind));
        end
    endtask

    // Random samples under random settings, across the idling phases.
    task automatic test_random_traffic();
        run_traffic_phase(0, 0);
        run_traffic_phase(87, 0);
        run_traffic_phase(0, 87);
        run_traffic_phase(11, 11);
    endtask

    // Hold the receiver off while items keep coming, so the output
    // register and the item in work fill up and the input stalls.
    task automatic test_output_backpressure();
        reg_image_t image;
        image[REG_FADER_MIN]   = 12'd0;
        image[REG_FADER_MAX]   = RAW_MAX;
        image[REG_KNOB_MIN]    = 12'd0;
        image[REG_KNOB_MAX]    = RAW_MAX;
        image[REG_PRESS_LEVEL] = PRESS_RESET;
        image[REG_FADER_BASE]  = 12'd16;
        image[REG_KNOB_BASE]   = 12'd32;
        image[REG_NOTE_BASE]   = 12'd48;
        load_config(image);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        // Second round always differs from the first, so it always reports.
        for (int i = 0; i < 16; i++)
            send_sample(KIND_FADER, IDX_W'(i % 8), (i < 8) ? 12'd0 : RAW_MAX);
        for (int i = 0; i < 8; i++)
            send_sample(KIND_BUTTON, IDX_W'(i), (i % 2) ? 12'd0 : RAW_MAX);
    endtask

    initial
    begin
        reset_shadow();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ranges_and_bases();
        test_inverted_and_tiny_ranges();
        test_random_traffic();
        test_output_backpressure();

        drain_scanner();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
